### rtl/core/rfst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfst_pkg;

   localparam int MODE_W     = 2;
   localparam int TIME_W     = 48;
   localparam int MEAN_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int SEQ_W      = 32;
   localparam int SKIP_W     = 8;
   localparam int GAP_CFG_W  = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [MODE_W-1:0] MODE_COLOR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEPTH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ARM   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_IGNORED     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAVED       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_SKIPPED     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_SYNC = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_LENS_COVER  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_ARMED       = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_SAVE_SEQUENCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_SKIP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAME_WINDOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_TIMEOUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LENS_THRESH   = 3'd4;

   localparam logic [GAP_CFG_W-1:0] WINDOW_RESET  = 24'd10000;
   localparam logic [GAP_CFG_W-1:0] TIMEOUT_RESET = 24'd2000000;
   localparam logic [MEAN_W-1:0]    LENS_RESET    = 16'd16250;

   typedef struct packed {
      logic capture;
      logic decide;
      logic new_check;
      logic scan_cmp;
      logic div_step;
      logic push;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic direct;
      logic other_empty;
      logic newer;
      logic scan_last;
      logic found;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

### rtl/core/rfst_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rfst_req_if;
   logic                         valid;
   logic                         ready;
   logic [rfst_pkg::MODE_W-1:0]  mode;
   logic [rfst_pkg::TIME_W-1:0]  frame_time_us;
   logic [rfst_pkg::MEAN_W-1:0]  depth_mean;
   modport source (output valid, mode, frame_time_us, depth_mean, input ready);
   modport sink (input valid, mode, frame_time_us, depth_mean, output ready);
endinterface

interface rfst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rfst_pkg::STATUS_W-1:0] status;
   logic [rfst_pkg::SEQ_W-1:0]    sequence_number;
   modport source (output valid, status, sequence_number, input ready);
   modport sink (input valid, status, sequence_number, output ready);
endinterface

interface rfst_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rfst_pkg::CSR_IDX_W-1:0]  index;
   logic [rfst_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/rfst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rfst_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 10
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

`default_nettype wire

### rtl/core/rfst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rfst_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output rfst_pkg::cmd_type       cmd,
   input  wire rfst_pkg::stat_type stat
);
   import rfst_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_DECIDE    = 9'b000000010,
      S_NEW_WAIT  = 9'b000000100,
      S_NEW_CHK   = 9'b000001000,
      S_SCAN_CMP  = 9'b000010000,
      S_SCAN_WAIT = 9'b000100000,
      S_DIV       = 9'b001000000,
      S_PUSH      = 9'b010000000,
      S_EMIT      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.direct)           state_in = S_EMIT;
            else if (stat.other_empty) state_in = S_DIV;
            else                       state_in = S_NEW_WAIT;
         end
         S_NEW_WAIT: state_in = S_NEW_CHK;
         S_NEW_CHK: begin
            cmd.new_check = 1'b1;
            state_in = stat.newer ? S_DIV : S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            if (stat.scan_last) state_in = stat.found ? S_DIV : S_EMIT;
            else                state_in = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: state_in = S_SCAN_CMP;
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_PUSH;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = stat.out_free;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

`default_nettype wire

### rtl/core/rfst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rfst_datapath #(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rfst_pkg::cmd_type                 cmd,
   output rfst_pkg::stat_type                     stat,
   input  wire logic                              csr_valid,
   input  wire logic [rfst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rfst_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic [rfst_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [rfst_pkg::TIME_W-1:0]       req_time,
   input  wire logic [rfst_pkg::MEAN_W-1:0]       req_mean,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [rfst_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [rfst_pkg::SEQ_W-1:0]        rsp_seq
);
   import rfst_pkg::*;

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int EW = SEQ_W + TIME_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(HISTORY_DEPTH);

   // configuration
   logic                 save_seq_ff, save_seq_in;
   logic [SKIP_W-1:0]    skip_ff, skip_in;
   logic [GAP_CFG_W-1:0] window_ff, window_in;
   logic [GAP_CFG_W-1:0] timeout_ff, timeout_in;
   logic [MEAN_W-1:0]    lens_thr_ff, lens_thr_in;
   // control state
   logic [SEQ_W-1:0]     counter_ff, counter_in;
   logic                 lens_ff, lens_in;
   logic                 arm_ff, arm_in;
   logic [AW-1:0]        col_ptr_ff, col_ptr_in, dep_ptr_ff, dep_ptr_in;
   logic [CW-1:0]        col_cnt_ff, col_cnt_in, dep_cnt_ff, dep_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // working payload
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [MEAN_W-1:0]    mean_ff, mean_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [TIME_W-1:0]    best_ff, best_in;
   logic                 found_ff, found_in;
   logic [CW-1:0]        remain_ff, remain_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [SKIP_W-1:0]    rem_ff, rem_in;
   logic [4:0]           bit_ff, bit_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [SEQ_W-1:0]     out_seq_ff, out_seq_in;

   logic [EW-1:0]     col_q, dep_q, oth_q;
   logic              is_depth, saving, mean_high, newer, scan_hit, out_free;
   logic [AW-1:0]     oth_ptr, own_ptr, own_ptr_next, newest_addr, prev_addr;
   logic [CW-1:0]     oth_cnt, own_cnt;
   logic [SEQ_W-1:0]  e_seq, seq_inc;
   logic [TIME_W-1:0] e_time, fwd_gap, abs_gap;
   logic [SKIP_W:0]   divisor, rem_sh, rem_sub;
   logic              direct;

   assign is_depth    = (mode_ff == MODE_DEPTH);
   assign oth_ptr     = is_depth ? col_ptr_ff : dep_ptr_ff;
   assign oth_cnt     = is_depth ? col_cnt_ff : dep_cnt_ff;
   assign own_ptr     = is_depth ? dep_ptr_ff : col_ptr_ff;
   assign own_cnt     = is_depth ? dep_cnt_ff : col_cnt_ff;
   assign own_ptr_next = (own_ptr == LAST_ADDR) ? '0 : own_ptr + 1'b1;
   assign newest_addr = (oth_ptr == '0) ? LAST_ADDR : oth_ptr - 1'b1;
   assign prev_addr   = (rd_addr_ff == '0) ? LAST_ADDR : rd_addr_ff - 1'b1;
   assign oth_q       = is_depth ? col_q : dep_q;
   assign e_seq       = oth_q[EW-1:TIME_W];
   assign e_time      = oth_q[TIME_W-1:0];
   assign newer       = time_ff > e_time;
   assign fwd_gap     = time_ff - e_time;
   assign abs_gap     = newer ? fwd_gap : e_time - time_ff;
   assign scan_hit    = abs_gap < best_ff;
   assign saving      = save_seq_ff | arm_ff;
   assign mean_high   = mean_ff > lens_thr_ff;
   assign seq_inc     = counter_ff + 1'b1;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // restoring remainder, one dividend bit per step
   assign divisor = {1'b0, skip_ff} + 1'b1;
   assign rem_sh  = {rem_ff, seq_ff[~bit_ff]};
   assign rem_sub = (rem_sh >= divisor) ? rem_sh - divisor : rem_sh;

   always_comb begin
      case (mode_ff)
         MODE_COLOR: direct = !saving || lens_ff;
         MODE_DEPTH: direct = !saving || mean_high;
         default:    direct = 1'b1;
      endcase
   end

   always_comb begin
      stat.direct      = direct;
      stat.other_empty = (oth_cnt == '0);
      stat.newer       = newer;
      stat.scan_last   = (remain_ff == CW'(1));
      stat.found       = found_ff || scan_hit;
      stat.div_last    = (bit_ff == 5'd31);
      stat.out_free    = out_free;
   end

   always_comb begin
      save_seq_in   = save_seq_ff;
      skip_in       = skip_ff;
      window_in     = window_ff;
      timeout_in    = timeout_ff;
      lens_thr_in   = lens_thr_ff;
      counter_in    = counter_ff;
      lens_in       = lens_ff;
      arm_in        = arm_ff;
      col_ptr_in    = col_ptr_ff;
      dep_ptr_in    = dep_ptr_ff;
      col_cnt_in    = col_cnt_ff;
      dep_cnt_in    = dep_cnt_ff;
      mode_in       = mode_ff;
      time_in       = time_ff;
      mean_in       = mean_ff;
      seq_in        = seq_ff;
      status_in     = status_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      remain_in     = remain_ff;
      rd_addr_in    = rd_addr_ff;
      rem_in        = '0;
      bit_in        = '0;
      out_status_in = out_status_ff;
      out_seq_in    = out_seq_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_SAVE_SEQUENCE: save_seq_in = csr_data[0];
            REG_FRAME_SKIP:    skip_in     = csr_data[SKIP_W-1:0];
            REG_SAME_WINDOW:   window_in   = csr_data;
            REG_SYNC_TIMEOUT:  timeout_in  = csr_data;
            REG_LENS_THRESH:   lens_thr_in = csr_data[MEAN_W-1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         mode_in = req_mode;
         time_in = req_time;
         mean_in = req_mean;
      end

      if (cmd.decide) begin
         seq_in     = '0;
         status_in  = STATUS_IGNORED;
         rd_addr_in = newest_addr;
         if (mode_ff == MODE_ARM) begin
            arm_in    = 1'b1;
            status_in = STATUS_ARMED;
         end else if (is_depth && saving && mean_high) begin
            lens_in   = 1'b1;
            status_in = STATUS_LENS_COVER;
            if (save_seq_ff) counter_in = '0;
         end else if (!direct) begin
            if (is_depth) lens_in = 1'b0;
            if (oth_cnt == '0) begin
               counter_in = seq_inc;
               seq_in     = seq_inc;
            end
         end
      end

      if (cmd.new_check) begin
         best_in   = {{(TIME_W-GAP_CFG_W){1'b0}}, timeout_ff};
         found_in  = 1'b0;
         remain_in = oth_cnt;
         if (newer) begin
            if (fwd_gap < {{(TIME_W-GAP_CFG_W){1'b0}}, window_ff}) begin
               seq_in = e_seq;
            end else begin
               counter_in = seq_inc;
               seq_in     = seq_inc;
            end
         end
      end

      // newest entry first, strict compare keeps the newest on ties
      if (cmd.scan_cmp) begin
         remain_in  = remain_ff - 1'b1;
         rd_addr_in = prev_addr;
         if (scan_hit) begin
            best_in  = abs_gap;
            seq_in   = e_seq;
            found_in = 1'b1;
         end
         if (remain_ff == CW'(1) && !(found_ff || scan_hit)) begin
            seq_in    = '0;
            status_in = STATUS_OUT_OF_SYNC;
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_sub[SKIP_W-1:0];
         bit_in = bit_ff + 1'b1;
      end else if (cmd.push) begin
         rem_in = rem_ff;
      end

      if (cmd.push) begin
         if (is_depth) begin
            dep_ptr_in = own_ptr_next;
            if (own_cnt != FULL_CNT) dep_cnt_in = own_cnt + 1'b1;
         end else begin
            col_ptr_in = own_ptr_next;
            if (own_cnt != FULL_CNT) col_cnt_in = own_cnt + 1'b1;
         end
         if (rem_ff != '0) begin
            status_in = STATUS_SKIPPED;
         end else begin
            status_in = STATUS_SAVED;
            arm_in    = 1'b0;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         out_status_in = status_ff;
         out_seq_in    = seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         save_seq_ff  <= 1'b0;
         skip_ff      <= '0;
         window_ff    <= WINDOW_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         lens_thr_ff  <= LENS_RESET;
         counter_ff   <= '0;
         lens_ff      <= 1'b1;
         arm_ff       <= 1'b0;
         col_ptr_ff   <= '0;
         dep_ptr_ff   <= '0;
         col_cnt_ff   <= '0;
         dep_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         save_seq_ff  <= save_seq_in;
         skip_ff      <= skip_in;
         window_ff    <= window_in;
         timeout_ff   <= timeout_in;
         lens_thr_ff  <= lens_thr_in;
         counter_ff   <= counter_in;
         lens_ff      <= lens_in;
         arm_ff       <= arm_in;
         col_ptr_ff   <= col_ptr_in;
         dep_ptr_ff   <= dep_ptr_in;
         col_cnt_ff   <= col_cnt_in;
         dep_cnt_ff   <= dep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      time_ff       <= time_in;
      mean_ff       <= mean_in;
      seq_ff        <= seq_in;
      status_ff     <= status_in;
      best_ff       <= best_in;
      found_ff      <= found_in;
      remain_ff     <= remain_in;
      rd_addr_ff    <= rd_addr_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
      out_status_ff <= out_status_in;
      out_seq_ff    <= out_seq_in;
   end

   rfst_ram #(.WIDTH(EW), .DEPTH(HISTORY_DEPTH)) u_color_hist (
      .clock (clock),
      .we    (cmd.push && !is_depth),
      .waddr (own_ptr),
      .wdata ({seq_ff, time_ff}),
      .raddr (rd_addr_ff),
      .rdata (col_q)
   );

   rfst_ram #(.WIDTH(EW), .DEPTH(HISTORY_DEPTH)) u_depth_hist (
      .clock (clock),
      .we    (cmd.push && is_depth),
      .waddr (own_ptr),
      .wdata ({seq_ff, time_ff}),
      .raddr (rd_addr_ff),
      .rdata (dep_q)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_seq    = out_seq_ff;
endmodule

`default_nettype wire

### rtl/core/rgbd_frame_sync_tagger_core.sv
// Tags color and depth frame items with shared sequence numbers by matching each
// timestamp against a circular history (HISTORY_DEPTH entries) of the other stream,
// held in a small RAM. One item is worked at a time. Arm, ignored and lens-covered
// items go straight to the result; a frame against an empty history goes straight
// to the remainder; a frame newer than the history is checked against its newest
// entry first; an older frame scans the history, newest entry first, then takes the
// remainder, or goes to the result when it is out of sync. The time taken is set by
// the history scan through the RAM's registered read port and by the 32-step
// remainder for frame-skip decimation; a stalled output holds the controller.
// A finished result waits in an output register; the next item is taken as soon
// as the controller returns to idle. Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none

module rgbd_frame_sync_tagger_core #(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rfst_req_if.sink   req_chan,
   rfst_rsp_if.source rsp_chan,
   rfst_csr_if.sink   csr_chan
);
   import rfst_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   rfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rfst_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_valid  (csr_chan.valid),
      .csr_index  (csr_chan.index),
      .csr_data   (csr_chan.data),
      .req_mode   (req_chan.mode),
      .req_time   (req_chan.frame_time_us),
      .req_mean   (req_chan.depth_mean),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_status (rsp_chan.status),
      .rsp_seq    (rsp_chan.sequence_number)
   );
endmodule

`default_nettype wire

### rtl/core/rfst_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rfst_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic [rfst_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [rfst_pkg::SEQ_W-1:0]      rsp_seq
);
   import rfst_pkg::*;

   // one item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item in work");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_ARMED))
      else $error("result status out of range");

   a_untagged_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_IGNORED || rsp_status == STATUS_OUT_OF_SYNC ||
                     rsp_status == STATUS_LENS_COVER || rsp_status == STATUS_ARMED))
      |-> (rsp_seq == '0))
      else $error("untagged result carries a sequence number");

   // no result can come out in the cycle after an accept from an idle output
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      ((req_valid && req_ready) && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared too early");
endmodule

bind rgbd_frame_sync_tagger_core rfst_checker u_rfst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_status (rsp_chan.status),
   .rsp_seq    (rsp_chan.sequence_number)
);

`default_nettype wire
